/* src/framed_byte_ring_fifo_defines.svh */
// Assertion macros shared by the framed byte ring FIFO.
// Depends on nothing; included by the top-level module, which checks its own logic.
`ifndef FRAMED_BYTE_RING_FIFO_DEFINES_SVH
`define FRAMED_BYTE_RING_FIFO_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define FBRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define FBRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/fbrf_pkg.sv */
// Shared types and constants of the framed byte ring FIFO.
// Depends on nothing; used by the top level.
package fbrf_pkg;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_NO_ROOM    = 2'd1;
   localparam logic [1:0] STS_EMPTY      = 2'd2;
   localparam logic [1:0] STS_BAD_MARKER = 2'd3;

   localparam logic [3:0] FRAME_OVERHEAD = 4'd6;
   localparam logic [3:0] MAX_PAYLOAD    = 4'd8;
   localparam logic [3:0] LEN_OFFSET     = 4'd5;
   localparam int         FRAME_BITS     = 112;
   localparam int         REQ_BITS       = 104;
   localparam int         RSP_BITS       = 112;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PUSH = 4'b0010,
      S_POP  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

endpackage

/* src/framed_byte_ring_fifo.sv */
// Framed byte ring FIFO: stores frames as bytes in a ring RAM, one byte a cycle.
// Depends on fbrf_pkg, fbrf_ram and framed_byte_ring_fifo_defines.svh.
// Usage:
//   req channel: tuser carries the opcode (push, pop, clear); tdata carries the
//   identifier, length and payload of a push. Each accepted word gives exactly
//   one rsp word: tuser the status, tdata the popped frame and the fill level.
//   csr_we writes the marker byte; write it only while no word is in flight.
// Timing:
//   A push writes the frame bytes into the ring and a pop reads them back, one RAM
//   access per cycle; the done state then loads the response register, waiting
//   while that register still holds a response not yet taken by rsp_tready.
//   Empty, refused, clear and unused opcodes go from idle straight to the done
//   state; a pop with a bad marker stops after the marker byte. req_tready is high
//   only while the sequencer is idle, so no word is taken until the last is done.
// Reset:
//   Both ring indices, the state, the byte count, the marker and the response valid
//   clear; ring contents are not cleared and need no sweep.
// Stall:
//   A waiting response is held in its register; the next word is still taken,
//   worked on and its response held in the sequencer until the register frees.
`include "framed_byte_ring_fifo_defines.svh"

module framed_byte_ring_fifo #(
   parameter int RING_BYTES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // frame_id [31:0], payload_len [35:32], payload [99:36], zero [103:100]
   input  logic [fbrf_pkg::REQ_BITS-1:0] req_tdata,
   // opcode [1:0]
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_id [31:0], out_len [35:32], out_payload [99:36], fill_level [107:100],
   // zero [111:108]
   output logic [fbrf_pkg::RSP_BITS-1:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]                    rsp_tuser,
   input  logic                          csr_we,
   input  logic [7:0]                    csr_wdata
);

   localparam int IW = $clog2(RING_BYTES);
   localparam logic [IW-1:0] LAST_ADDR = IW'(RING_BYTES - 1);
   localparam logic [IW:0]   RING_W    = (IW+1)'(RING_BYTES);

   fbrf_pkg::state_type state_ff, state_in;

   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [3:0]    last_ff, last_in;
   logic [fbrf_pkg::FRAME_BITS-1:0] frame_ff, frame_in;
   logic [1:0]    status_ff, status_in;
   logic          pop_ok_ff, pop_ok_in;
   logic [7:0]    marker_ff, marker_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [fbrf_pkg::RSP_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_user_ff, rsp_user_in;

   logic          req_fire;
   logic [IW:0]   held_wide;
   logic [IW:0]   need_wide;
   logic          fits;
   logic [3:0]    in_len;
   logic [3:0]    len_sat;
   logic [IW-1:0] ptr_next;
   logic [3:0]    cap_idx;
   logic [3:0]    rd_len_sat;
   logic [31:0]   held32;
   logic [7:0]    fill_level;

   logic          ram_we;
   logic          ram_re;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   fbrf_ram #(
      .WIDTH(8),
      .DEPTH(RING_BYTES)
   ) u_ring (
      .clock(clock),
      .we   (ram_we),
      .waddr(ptr_ff),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ptr_ff),
      .rdata(ram_rdata)
   );

   assign req_tready = (state_ff == fbrf_pkg::S_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   assign held_wide = (wr_idx_ff >= rd_idx_ff) ?
                      ({1'b0, wr_idx_ff} - {1'b0, rd_idx_ff}) :
                      (RING_W - {1'b0, rd_idx_ff} + {1'b0, wr_idx_ff});
   assign held32     = 32'(held_wide);
   assign fill_level = held32[7:0];

   assign in_len    = req_tdata[35:32];
   assign len_sat   = (in_len > fbrf_pkg::MAX_PAYLOAD) ? fbrf_pkg::MAX_PAYLOAD : in_len;
   assign need_wide = held_wide + (IW+1)'(fbrf_pkg::FRAME_OVERHEAD) + (IW+1)'(len_sat);
   assign fits      = (need_wide < RING_W);

   assign ptr_next   = (ptr_ff == LAST_ADDR) ? '0 : ptr_ff + 1'b1;
   assign cap_idx    = cnt_ff - 4'd1;
   assign rd_len_sat = (ram_rdata > 8'(fbrf_pkg::MAX_PAYLOAD)) ?
                       fbrf_pkg::MAX_PAYLOAD : ram_rdata[3:0];
   assign ram_wdata  = 8'(frame_ff >> {cnt_ff, 3'b000});

   assign marker_in = csr_we ? csr_wdata : marker_ff;

   always_comb begin
      state_in     = state_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      frame_in     = frame_ff;
      status_in    = status_ff;
      pop_ok_in    = pop_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         fbrf_pkg::S_IDLE: begin
            if (req_fire) begin
               frame_in  = {req_tdata[99:36], 4'b0000, len_sat, req_tdata[31:0], marker_ff};
               status_in = fbrf_pkg::STS_OK;
               pop_ok_in = 1'b0;
               cnt_in    = '0;
               state_in  = fbrf_pkg::S_DONE;
               case (req_tuser)
                  fbrf_pkg::OP_PUSH: begin
                     if (fits) begin
                        ptr_in   = wr_idx_ff;
                        last_in  = fbrf_pkg::LEN_OFFSET + len_sat;
                        state_in = fbrf_pkg::S_PUSH;
                     end else begin
                        status_in = fbrf_pkg::STS_NO_ROOM;
                     end
                  end
                  fbrf_pkg::OP_POP: begin
                     if (wr_idx_ff == rd_idx_ff) begin
                        status_in = fbrf_pkg::STS_EMPTY;
                     end else begin
                        frame_in = '0;
                        ptr_in   = rd_idx_ff;
                        state_in = fbrf_pkg::S_POP;
                     end
                  end
                  fbrf_pkg::OP_CLEAR: begin
                     wr_idx_in = '0;
                     rd_idx_in = '0;
                  end
                  default: begin
                     status_in = fbrf_pkg::STS_OK;
                  end
               endcase
            end
         end
         fbrf_pkg::S_PUSH: begin
            ram_we = 1'b1;
            ptr_in = ptr_next;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == last_ff) begin
               wr_idx_in = ptr_next;
               state_in  = fbrf_pkg::S_DONE;
            end
         end
         fbrf_pkg::S_POP: begin
            ram_re = 1'b1;
            ptr_in = ptr_next;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff != 4'd0) begin
               frame_in[{cap_idx, 3'b000} +: 8] = ram_rdata;
               if (cap_idx == 4'd0) begin
                  if (ram_rdata != marker_ff) begin
                     status_in = fbrf_pkg::STS_BAD_MARKER;
                     state_in  = fbrf_pkg::S_DONE;
                  end
               end else if (cap_idx == fbrf_pkg::LEN_OFFSET) begin
                  frame_in[47:40] = {4'b0000, rd_len_sat};
                  last_in         = fbrf_pkg::LEN_OFFSET + rd_len_sat;
                  if (rd_len_sat == 4'd0) begin
                     rd_idx_in = ptr_ff;
                     pop_ok_in = 1'b1;
                     state_in  = fbrf_pkg::S_DONE;
                  end
               end else if ((cap_idx > fbrf_pkg::LEN_OFFSET) && (cap_idx == last_ff)) begin
                  rd_idx_in = ptr_ff;
                  pop_ok_in = 1'b1;
                  state_in  = fbrf_pkg::S_DONE;
               end
            end
         end
         fbrf_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {4'b0000, fill_level,
                               pop_ok_ff ? frame_ff[111:48] : 64'd0,
                               pop_ok_ff ? frame_ff[43:40]  : 4'd0,
                               pop_ok_ff ? frame_ff[39:8]   : 32'd0};
               state_in     = fbrf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fbrf_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbrf_pkg::S_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         cnt_ff       <= '0;
         marker_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         cnt_ff       <= cnt_in;
         marker_ff    <= marker_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      last_ff     <= last_in;
      frame_ff    <= frame_in;
      status_ff   <= status_in;
      pop_ok_ff   <= pop_ok_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `FBRF_ASSERT_NOW(a_idx_range, clock, reset, 1'b1, (wr_idx_ff <= LAST_ADDR) && (rd_idx_ff <= LAST_ADDR), "ring index beyond ring size")
   `FBRF_ASSERT_NEXT(a_push_keeps_rd, clock, reset, state_ff == fbrf_pkg::S_PUSH, $stable(rd_idx_ff), "push moved the read index")
   `FBRF_ASSERT_NOW(a_push_count, clock, reset, state_ff == fbrf_pkg::S_PUSH, cnt_ff <= last_ff, "push ran past the frame end")
   `FBRF_ASSERT_NEXT(a_clear_idx, clock, reset, req_fire && (req_tuser == fbrf_pkg::OP_CLEAR), (wr_idx_ff == '0) && (rd_idx_ff == '0), "clear left an index set")

endmodule

/* src/fbrf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; instanced by the framed byte ring FIFO.
module fbrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* test/framed_byte_ring_fifo_test.sv */
// Self-checking bench for framed_byte_ring_fifo: drives push, pop, clear and unused-opcode words,
// checks every response word against a byte-level ring tracker held in a small class.
// Depends on fbrf_pkg and the framed_byte_ring_fifo RTL only.
`timescale 1ns / 100ps

module framed_byte_ring_fifo_test;

   localparam int         RING_BYTES = 256;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] id;
      logic [3:0]  len;
      logic [63:0] payload;
      logic [7:0]  fill;
   } ring_reply_type;

   class frame_ring_tracker;
      logic [7:0]     ring_bytes [RING_BYTES];
      int             wr_ptr;
      int             rd_ptr;
      logic [7:0]     marker;
      ring_reply_type pending_replies [$];
      int             mismatches;
      int             replies_seen;
      int             status_count [4];

      function new();
         wr_ptr = 0;
         rd_ptr = 0;
         marker = 8'h00;
         mismatches = 0;
         replies_seen = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      function int held();
         return (wr_ptr - rd_ptr + RING_BYTES) % RING_BYTES;
      endfunction

      function void put_byte(logic [7:0] b);
         ring_bytes[wr_ptr] = b;
         wr_ptr = (wr_ptr + 1) % RING_BYTES;
      endfunction

      function logic [7:0] peek(int k);
         return ring_bytes[(rd_ptr + k) % RING_BYTES];
      endfunction

      function void note_word(logic [1:0] op, logic [31:0] id, logic [3:0] len,
                              logic [63:0] data);
         ring_reply_type r;
         int             n;
         r = '0;
         n = (len > fbrf_pkg::MAX_PAYLOAD) ? int'(fbrf_pkg::MAX_PAYLOAD) : int'(len);
         case (op)
            fbrf_pkg::OP_PUSH: begin
               if (RING_BYTES - 1 - held() < int'(fbrf_pkg::FRAME_OVERHEAD) + n) begin
                  r.status = fbrf_pkg::STS_NO_ROOM;
               end else begin
                  put_byte(marker);
                  for (int i = 0; i < 4; i++) put_byte(id[8*i +: 8]);
                  put_byte(8'(n));
                  for (int i = 0; i < n; i++) put_byte(data[8*i +: 8]);
               end
            end
            fbrf_pkg::OP_POP: begin
               if (held() == 0) begin
                  r.status = fbrf_pkg::STS_EMPTY;
               end else if (peek(0) != marker) begin
                  r.status = fbrf_pkg::STS_BAD_MARKER;
               end else begin
                  for (int i = 0; i < 4; i++) r.id[8*i +: 8] = peek(1 + i);
                  n = int'(peek(int'(fbrf_pkg::LEN_OFFSET)));
                  if (n > int'(fbrf_pkg::MAX_PAYLOAD)) n = int'(fbrf_pkg::MAX_PAYLOAD);
                  r.len = 4'(n);
                  for (int i = 0; i < n; i++)
                     r.payload[8*i +: 8] = peek(int'(fbrf_pkg::FRAME_OVERHEAD) + i);
                  rd_ptr = (rd_ptr + int'(fbrf_pkg::FRAME_OVERHEAD) + n) % RING_BYTES;
               end
            end
            fbrf_pkg::OP_CLEAR: begin
               wr_ptr = 0;
               rd_ptr = 0;
            end
            default: ;
         endcase
         r.fill = 8'(held());
         status_count[r.status]++;
         pending_replies.push_back(r);
      endfunction

      task report(string field, logic [63:0] got, logic [63:0] want);
         mismatches++;
         $display("reply %0d: %s got %h, expected %h", replies_seen, field, got, want);
      endtask

      task check_word(logic [1:0] sts, logic [fbrf_pkg::RSP_BITS-1:0] data);
         ring_reply_type want;
         replies_seen++;
         if (pending_replies.size() == 0) begin
            report("reply with nothing pending", {62'b0, sts}, 64'b0);
            return;
         end
         want = pending_replies.pop_front();
         if (sts !== want.status)
            report("status", 64'(sts), 64'(want.status));
         if (data[31:0] !== want.id)
            report("out_id", 64'(data[31:0]), 64'(want.id));
         if (data[35:32] !== want.len)
            report("out_len", 64'(data[35:32]), 64'(want.len));
         if (data[99:36] !== want.payload)
            report("out_payload", data[99:36], want.payload);
         if (data[107:100] !== want.fill)
            report("fill_level", 64'(data[107:100]), 64'(want.fill));
      endtask

      task flush_check();
         while (pending_replies.size() != 0) begin
            void'(pending_replies.pop_front());
            report("reply never arrived", 64'b0, 64'b0);
         end
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [fbrf_pkg::REQ_BITS-1:0] req_tdata = '0;
   logic [1:0]                    req_tuser = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [fbrf_pkg::RSP_BITS-1:0] rsp_tdata;
   logic [1:0]                    rsp_tuser;
   logic                          csr_we = 1'b0;
   logic [7:0]                    csr_wdata = '0;
   logic                          rsp_hold = 1'b0;

   int                  send_idle_pct = 0;
   int                  rsp_stall_pct = 0;
   int                  words_sent = 0;

   frame_ring_tracker   ring_track = new();

   framed_byte_ring_fifo #(
      .RING_BYTES(RING_BYTES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ring_track.check_word(rsp_tuser, rsp_tdata);
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic hold_receiver(input int cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   task automatic send_word(input logic [1:0] op, input logic [31:0] id,
                            input logic [3:0] len, input logic [63:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, data, len, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ring_track.note_word(op, id, len, data);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (ring_track.pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_marker(input logic [7:0] value);
      wait_drained();
      repeat (20) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      ring_track.marker = value;
   endtask

   function automatic logic [3:0] pick_len();
      if ($urandom_range(99) < 85) return 4'($urandom_range(8));
      return 4'($urandom_range(15, 9));
   endfunction

   task automatic run_random(input int words, input int idle_pct, input int stall_pct);
      int         push_bias;
      int         pick;
      logic [1:0] op;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      push_bias = 50;
      for (int k = 0; k < words; k++) begin
         if (k % 40 == 0) push_bias = $urandom_range(75, 30);
         pick = $urandom_range(99);
         if (pick < 3)                                 op = fbrf_pkg::OP_CLEAR;
         else if (pick < 6)                            op = OP_UNUSED;
         else if ($urandom_range(99) < push_bias)      op = fbrf_pkg::OP_PUSH;
         else                                          op = fbrf_pkg::OP_POP;
         send_word(op, $urandom, pick_len(), {$urandom, $urandom});
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(fbrf_pkg::OP_POP, 32'h0, 4'd0, 64'h0);
      send_word(fbrf_pkg::OP_PUSH, 32'h0, 4'd0, 64'h0);
      send_word(fbrf_pkg::OP_PUSH, 32'hFFFF_FFFF, 4'd8, '1);
      send_word(fbrf_pkg::OP_PUSH, 32'h1234_5678, 4'd15, 64'h0123_4567_89AB_CDEF);
      send_word(fbrf_pkg::OP_POP, 32'h0, 4'd0, 64'h0);
      send_word(fbrf_pkg::OP_POP, 32'h0, 4'd0, 64'h0);
      send_word(fbrf_pkg::OP_POP, 32'h0, 4'd0, 64'h0);
      send_word(fbrf_pkg::OP_POP, 32'h0, 4'd0, 64'h0);
      send_word(OP_UNUSED, $urandom, 4'd5, {$urandom, $urandom});
      send_word(fbrf_pkg::OP_PUSH, 32'h8000_0001, 4'd3, 64'hFFFF_FFFF_FF5A_C3A5);
      send_word(fbrf_pkg::OP_CLEAR, 32'h0, 4'd0, 64'h0);
      send_word(fbrf_pkg::OP_POP, 32'h0, 4'd0, 64'h0);

      write_marker(8'hFF);
      send_word(fbrf_pkg::OP_PUSH, 32'hDEAD_BEEF, 4'd1, 64'h0000_0000_0000_00FF);
      send_word(fbrf_pkg::OP_PUSH, 32'h0F0F_F0F0, 4'd9, {$urandom, $urandom});
      send_word(fbrf_pkg::OP_POP, 32'h0, 4'd0, 64'h0);

      write_marker(8'h00);
      send_word(fbrf_pkg::OP_POP, 32'h0, 4'd0, 64'h0);
      send_word(fbrf_pkg::OP_PUSH, 32'h0000_00FF, 4'd2, 64'hAAAA);
      send_word(fbrf_pkg::OP_POP, 32'h0, 4'd0, 64'h0);
      send_word(fbrf_pkg::OP_CLEAR, 32'h0, 4'd0, 64'h0);
      send_word(fbrf_pkg::OP_POP, 32'h0, 4'd0, 64'h0);

      write_marker(8'hA5);
      run_random(370, 0, 0);

      // hold the receiver while pushes keep coming, then drain and empty the ring
      wait_drained();
      send_word(fbrf_pkg::OP_CLEAR, 32'h0, 4'd0, 64'h0);
      fork
         hold_receiver(300);
      join_none
      for (int k = 0; k < 24; k++)
         send_word(fbrf_pkg::OP_PUSH, $urandom, 4'd8, {$urandom, $urandom});
      wait_drained();
      for (int k = 0; k < 20; k++) send_word(fbrf_pkg::OP_POP, $urandom, pick_len(), 64'h0);

      write_marker(8'($urandom));
      send_word(fbrf_pkg::OP_CLEAR, 32'h0, 4'd0, 64'h0);
      run_random(370, 76, 0);

      write_marker(8'hFF);
      run_random(370, 0, 76);

      write_marker(8'h00);
      send_word(fbrf_pkg::OP_CLEAR, 32'h0, 4'd0, 64'h0);
      run_random(370, 25, 25);

      wait_drained();
      repeat (40) @(posedge clock);
      ring_track.flush_check();

      $display("Covered %0d words over four idle/stall mixes and several marker values.",
               words_sent);
      $display("Replies: %0d ok, %0d no room, %0d empty, %0d bad marker.",
               ring_track.status_count[fbrf_pkg::STS_OK],
               ring_track.status_count[fbrf_pkg::STS_NO_ROOM],
               ring_track.status_count[fbrf_pkg::STS_EMPTY],
               ring_track.status_count[fbrf_pkg::STS_BAD_MARKER]);
      if (ring_track.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #3200000;
      $display("Timed out with %0d replies outstanding.", ring_track.pending_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
